>>> hdl/fet_pkg.sv
// Shared constants, register codes and pipeline control type for the escape-time iterator.
package fet_pkg;

	localparam int FET_WORD_WIDTH = 32;
	localparam int FET_FRAC_BITS  = 22;

	// Depth of the recirculating iteration ring: s1 entry, s2..s3 multiply, s4..s5 escape.
	localparam int RING_STAGES = 5;
	localparam int TAG_W       = $clog2(RING_STAGES) + 1;
	localparam int CNT_W       = 8;
	localparam int EXP_W       = 3;
	localparam int CFG_IDX_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOLID_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JULIA_SELECT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_RE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_IM   = 3'd5;

	localparam logic [CNT_W-1:0] MAX_ITER_RST = 8'd40;
	localparam logic [EXP_W-1:0] EXPONENT_RST = 3'd2;

	// Control that travels with each point around the ring.
	typedef struct packed {
		logic             vld;
		logic             done;
		logic             esc;
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] n;
		logic [1:0]       k;     // complex multiplies left in this iteration
	} fet_ctl_t;

endpackage

>>> hdl/fet_point_if.sv
// Input channel: one complex point per transaction.
interface fet_point_if import fet_pkg::*; #(parameter int WORD_WIDTH = FET_WORD_WIDTH);
	logic                         valid;
	logic                         ready;
	logic signed [WORD_WIDTH-1:0] point_re;
	logic signed [WORD_WIDTH-1:0] point_im;

	modport source (output valid, output point_re, output point_im, input ready);
	modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

>>> hdl/fet_result_if.sv
// Output channel: escape count and flag per transaction.
interface fet_result_if import fet_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] iter_count;
	logic             escaped;

	modport source (output valid, output iter_count, output escaped, input ready);
	modport sink   (input valid, input iter_count, input escaped, output ready);
endinterface

>>> hdl/fet_cmul.sv
// Two-stage complex multiplier w*z with floor scaling and saturation.
module fet_cmul import fet_pkg::*; #(
	parameter int WORD_WIDTH = FET_WORD_WIDTH,
	parameter int FRAC_BITS  = FET_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fet_ctl_t                     ctl_s1,
	input  logic signed [WORD_WIDTH-1:0] wr_s1,
	input  logic signed [WORD_WIDTH-1:0] wi_s1,
	input  logic signed [WORD_WIDTH-1:0] zr_s1,
	input  logic signed [WORD_WIDTH-1:0] zi_s1,
	input  logic signed [WORD_WIDTH-1:0] cr_s1,
	input  logic signed [WORD_WIDTH-1:0] ci_s1,
	output fet_ctl_t                     ctl_s3,
	output logic signed [WORD_WIDTH-1:0] pr_s3,
	output logic signed [WORD_WIDTH-1:0] pi_s3,
	output logic signed [WORD_WIDTH-1:0] zr_s3,
	output logic signed [WORD_WIDTH-1:0] zi_s3,
	output logic signed [WORD_WIDTH-1:0] cr_s3,
	output logic signed [WORD_WIDTH-1:0] ci_s3
);

	localparam int PW = 2 * WORD_WIDTH;
	localparam int QW = PW - FRAC_BITS;
	localparam logic [WORD_WIDTH-1:0] SMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] SMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	fet_ctl_t                     ctl_s2;
	logic signed [PW-1:0]         p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [WORD_WIDTH-1:0] zr_s2, zi_s2, cr_s2, ci_s2;
	logic signed [WORD_WIDTH-1:0] a_rr, a_ii, a_ri, a_ir;
	logic signed [WORD_WIDTH-1:0] re_nx, im_nx;

	// Arithmetic shift is floor; then clamp to the word range.
	function automatic logic [WORD_WIDTH-1:0] scale_sat(input logic [PW-1:0] p);
		logic [QW-1:0]           q;
		logic [QW-WORD_WIDTH:0]  hi;
		q  = p[PW-1:FRAC_BITS];
		hi = q[QW-1:WORD_WIDTH-1];
		if ((&hi) || !(|hi))
			return q[WORD_WIDTH-1:0];
		return q[QW-1] ? SMIN : SMAX;
	endfunction

	function automatic logic [WORD_WIDTH-1:0] sat1(input logic [WORD_WIDTH:0] v);
		if (v[WORD_WIDTH] == v[WORD_WIDTH-1])
			return v[WORD_WIDTH-1:0];
		return v[WORD_WIDTH] ? SMIN : SMAX;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_comb begin
		a_rr  = scale_sat(p_rr_s2);
		a_ii  = scale_sat(p_ii_s2);
		a_ri  = scale_sat(p_ri_s2);
		a_ir  = scale_sat(p_ir_s2);
		re_nx = sat1({a_rr[WORD_WIDTH-1], a_rr} - {a_ii[WORD_WIDTH-1], a_ii});
		im_nx = sat1({a_ri[WORD_WIDTH-1], a_ri} + {a_ir[WORD_WIDTH-1], a_ir});
	end

	always_ff @(posedge clk) begin
		p_rr_s2 <= wr_s1 * zr_s1;
		p_ii_s2 <= wi_s1 * zi_s1;
		p_ri_s2 <= wr_s1 * zi_s1;
		p_ir_s2 <= wi_s1 * zr_s1;
		zr_s2   <= zr_s1;
		zi_s2   <= zi_s1;
		cr_s2   <= cr_s1;
		ci_s2   <= ci_s1;
		pr_s3   <= re_nx;
		pi_s3   <= im_nx;
		zr_s3   <= zr_s2;
		zi_s3   <= zi_s2;
		cr_s3   <= cr_s2;
		ci_s3   <= ci_s2;
	end

endmodule

>>> hdl/fet_escape.sv
// Two-stage add of c on the last multiply of an iteration, then squares and escape test.
module fet_escape import fet_pkg::*; #(
	parameter int WORD_WIDTH = FET_WORD_WIDTH,
	parameter int FRAC_BITS  = FET_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fet_ctl_t                     ctl_s3,
	input  logic signed [WORD_WIDTH-1:0] pr_s3,
	input  logic signed [WORD_WIDTH-1:0] pi_s3,
	input  logic signed [WORD_WIDTH-1:0] zr_s3,
	input  logic signed [WORD_WIDTH-1:0] zi_s3,
	input  logic signed [WORD_WIDTH-1:0] cr_s3,
	input  logic signed [WORD_WIDTH-1:0] ci_s3,
	output fet_ctl_t                     ctl_s5,
	output logic signed [WORD_WIDTH-1:0] znr_s5,
	output logic signed [WORD_WIDTH-1:0] zni_s5,
	output logic signed [WORD_WIDTH-1:0] zr_s5,
	output logic signed [WORD_WIDTH-1:0] zi_s5,
	output logic signed [WORD_WIDTH-1:0] cr_s5,
	output logic signed [WORD_WIDTH-1:0] ci_s5,
	output logic                         esc_hit
);

	localparam int PW = 2 * WORD_WIDTH;
	localparam logic [WORD_WIDTH-1:0] SMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] SMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam logic signed [WORD_WIDTH+1:0] LIM_P = (WORD_WIDTH+2)'(longint'(4) << FRAC_BITS);
	localparam logic signed [WORD_WIDTH+1:0] LIM_N = -LIM_P;
	// |z|^2 > 16 in the squared scale
	localparam logic [PW-1:0] THR = PW'(1) << (2 * FRAC_BITS + 4);

	fet_ctl_t                     ctl_s4;
	logic signed [WORD_WIDTH-1:0] znr_s4, zni_s4, zr_s4, zi_s4, cr_s4, ci_s4;
	logic signed [WORD_WIDTH-1:0] znr_nx, zni_nx;
	logic signed [PW-1:0]         sq_re_s5, sq_im_s5;
	logic                         big_s5;
	logic signed [WORD_WIDTH+1:0] re_x, im_x;
	logic [PW-1:0]                mag_sq;

	function automatic logic [WORD_WIDTH-1:0] sat1(input logic [WORD_WIDTH:0] v);
		if (v[WORD_WIDTH] == v[WORD_WIDTH-1])
			return v[WORD_WIDTH-1:0];
		return v[WORD_WIDTH] ? SMIN : SMAX;
	endfunction

	always_comb begin
		znr_nx = pr_s3;
		zni_nx = pi_s3;
		if (ctl_s3.k == 2'd1) begin
			znr_nx = sat1({pr_s3[WORD_WIDTH-1], pr_s3} + {cr_s3[WORD_WIDTH-1], cr_s3});
			zni_nx = sat1({pi_s3[WORD_WIDTH-1], pi_s3} + {ci_s3[WORD_WIDTH-1], ci_s3});
		end
		re_x = {{2{znr_s4[WORD_WIDTH-1]}}, znr_s4};
		im_x = {{2{zni_s4[WORD_WIDTH-1]}}, zni_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		znr_s4   <= znr_nx;
		zni_s4   <= zni_nx;
		zr_s4    <= zr_s3;
		zi_s4    <= zi_s3;
		cr_s4    <= cr_s3;
		ci_s4    <= ci_s3;
		sq_re_s5 <= znr_s4 * znr_s4;
		sq_im_s5 <= zni_s4 * zni_s4;
		big_s5   <= (re_x > LIM_P) || (re_x < LIM_N) || (im_x > LIM_P) || (im_x < LIM_N);
		znr_s5   <= znr_s4;
		zni_s5   <= zni_s4;
		zr_s5    <= zr_s4;
		zi_s5    <= zi_s4;
		cr_s5    <= cr_s4;
		ci_s5    <= ci_s4;
	end

	// Squares are non-negative and at most 2^(PW-2) each, so the unsigned sum cannot wrap.
	assign mag_sq  = $unsigned(sq_re_s5) + $unsigned(sq_im_s5);
	assign esc_hit = big_s5 || (mag_sq > THR);

endmodule

>>> hdl/fractal_escape_time_iterator.sv
// Top level: config registers, recirculating iteration ring and in-order result register.
//
// Usage: points enter on the point channel (valid/ready), one escape count plus
// escaped flag leaves on the result channel for every point, in entry order.
// Registers are written through cfg_we/cfg_idx/cfg_wdata; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// Datapath: a 5-stage ring (entry, two complex-multiply stages, two escape
// stages). Each pass around the ring is one complex multiply, so one iteration
// takes p-1 passes (p = power, 2 in Julia mode). Up to 5 points share the ring,
// one per stage; a new point enters whenever the slot reaching the end of the
// ring is empty or leaves to the output register. A point with a zero limit is
// finished on entry; a point that escapes early finishes before the full limit.
// A finished point waits in the ring until all older points have left, which
// keeps results in order.
// Reset: registers take their reset values, ring and output register are emptied.
// When the receiver stalls, finished points keep circulating and entry stops once
// the ring is full; nothing is dropped.
module fractal_escape_time_iterator import fet_pkg::*; #(
	parameter int WORD_WIDTH = FET_WORD_WIDTH,
	parameter int FRAC_BITS  = FET_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [WORD_WIDTH-1:0] cfg_wdata,
	fet_point_if.sink             point,
	fet_result_if.source          result
);

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam logic [WORD_WIDTH-1:0] JC_RE_RST = WORD_WIDTH'(-((4 * ONE + 5) / 10));
	localparam logic [WORD_WIDTH-1:0] JC_IM_RST = WORD_WIDTH'(-((59 * ONE + 50) / 100));

	logic [CNT_W-1:0]             max_iter_q;
	logic [EXP_W-1:0]             exponent_q;
	logic                         solid_q;
	logic                         julia_q;
	logic signed [WORD_WIDTH-1:0] jc_re_q, jc_im_q;

	fet_ctl_t                     ctl_s1, ctl_s3, ctl_s5, nx_ctl, new_ctl;
	logic signed [WORD_WIDTH-1:0] wr_s1, wi_s1, zr_s1, zi_s1, cr_s1, ci_s1;
	logic signed [WORD_WIDTH-1:0] pr_s3, pi_s3, zr_s3, zi_s3, cr_s3, ci_s3;
	logic signed [WORD_WIDTH-1:0] znr_s5, zni_s5, zr_s5, zi_s5, cr_s5, ci_s5;
	logic signed [WORD_WIDTH-1:0] nx_wr, nx_wi, nx_zr, nx_zi, nx_cr, nx_ci;
	logic signed [WORD_WIDTH-1:0] new_zr, new_zi, new_cr, new_ci;
	logic                         esc_hit;
	logic [1:0]                   kp;
	logic [TAG_W-1:0]             in_tag_q, out_tag_q;
	logic                         out_vld_q, out_esc_q;
	logic [CNT_W-1:0]             out_cnt_q;
	logic                         out_free, emit, slot_free, take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
			exponent_q <= EXPONENT_RST;
			solid_q    <= 1'b0;
			julia_q    <= 1'b0;
			jc_re_q    <= JC_RE_RST;
			jc_im_q    <= JC_IM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_ITER:     max_iter_q <= cfg_wdata[CNT_W-1:0];
				REG_EXPONENT:     exponent_q <= cfg_wdata[EXP_W-1:0];
				REG_SOLID_MODE:   solid_q    <= cfg_wdata[0];
				REG_JULIA_SELECT: julia_q    <= cfg_wdata[0];
				REG_JULIA_C_RE:   jc_re_q    <= cfg_wdata;
				REG_JULIA_C_IM:   jc_im_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Multiplies per iteration: power - 1, power clamped to 2..4, fixed at 2 for Julia.
	always_comb begin
		if (julia_q)
			kp = 2'd1;
		else if (exponent_q inside {[3'd4:3'd7]})
			kp = 2'd3;
		else if (exponent_q == 3'd3)
			kp = 2'd2;
		else
			kp = 2'd1;
	end

	fet_cmul #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cmul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.wr_s1  (wr_s1),
		.wi_s1  (wi_s1),
		.zr_s1  (zr_s1),
		.zi_s1  (zi_s1),
		.cr_s1  (cr_s1),
		.ci_s1  (ci_s1),
		.ctl_s3 (ctl_s3),
		.pr_s3  (pr_s3),
		.pi_s3  (pi_s3),
		.zr_s3  (zr_s3),
		.zi_s3  (zi_s3),
		.cr_s3  (cr_s3),
		.ci_s3  (ci_s3)
	);

	fet_escape #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_escape (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s3  (ctl_s3),
		.pr_s3   (pr_s3),
		.pi_s3   (pi_s3),
		.zr_s3   (zr_s3),
		.zi_s3   (zi_s3),
		.cr_s3   (cr_s3),
		.ci_s3   (ci_s3),
		.ctl_s5  (ctl_s5),
		.znr_s5  (znr_s5),
		.zni_s5  (zni_s5),
		.zr_s5   (zr_s5),
		.zi_s5   (zi_s5),
		.cr_s5   (cr_s5),
		.ci_s5   (ci_s5),
		.esc_hit (esc_hit)
	);

	// End of ring: advance the slot by one multiply, or close its iteration.
	always_comb begin
		nx_ctl = ctl_s5;
		nx_wr  = znr_s5;
		nx_wi  = zni_s5;
		nx_zr  = zr_s5;
		nx_zi  = zi_s5;
		nx_cr  = cr_s5;
		nx_ci  = ci_s5;
		if (ctl_s5.vld && !ctl_s5.done) begin
			if (ctl_s5.k == 2'd1) begin
				nx_zr = znr_s5;
				nx_zi = zni_s5;
				if (esc_hit) begin
					nx_ctl.done = 1'b1;
					nx_ctl.esc  = 1'b1;
					nx_ctl.cnt  = solid_q ? '0 : ctl_s5.n;
				end else if ({1'b0, ctl_s5.n} + 9'd1 == {1'b0, max_iter_q}) begin
					nx_ctl.done = 1'b1;
					nx_ctl.esc  = 1'b0;
					nx_ctl.cnt  = max_iter_q;
				end else begin
					nx_ctl.n = ctl_s5.n + 8'd1;
					nx_ctl.k = kp;
				end
			end else begin
				nx_ctl.k = ctl_s5.k - 2'd1;
			end
		end
	end

	assign out_free  = !out_vld_q || result.ready;
	// Only the oldest point in flight may leave.
	assign emit      = nx_ctl.vld && nx_ctl.done && (nx_ctl.tag == out_tag_q) && out_free;
	assign slot_free = !nx_ctl.vld || emit;
	assign take      = point.valid && slot_free;
	assign point.ready = slot_free;

	always_comb begin
		if (julia_q) begin
			new_zr = point.point_re;
			new_zi = point.point_im;
			new_cr = jc_re_q;
			new_ci = jc_im_q;
		end else begin
			new_zr = '0;
			new_zi = '0;
			new_cr = point.point_re;
			new_ci = point.point_im;
		end
		new_ctl      = '0;
		new_ctl.vld  = 1'b1;
		new_ctl.done = (max_iter_q == '0);
		new_ctl.tag  = in_tag_q;
		new_ctl.k    = kp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			in_tag_q  <= '0;
			out_tag_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (take)
				ctl_s1 <= new_ctl;
			else if (emit)
				ctl_s1 <= '0;
			else
				ctl_s1 <= nx_ctl;
			if (take)
				in_tag_q <= in_tag_q + 1'b1;
			if (emit)
				out_tag_q <= out_tag_q + 1'b1;
			if (emit)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			wr_s1 <= new_zr;
			wi_s1 <= new_zi;
			zr_s1 <= new_zr;
			zi_s1 <= new_zi;
			cr_s1 <= new_cr;
			ci_s1 <= new_ci;
		end else begin
			wr_s1 <= nx_wr;
			wi_s1 <= nx_wi;
			zr_s1 <= nx_zr;
			zi_s1 <= nx_zi;
			cr_s1 <= nx_cr;
			ci_s1 <= nx_ci;
		end
		if (emit) begin
			out_cnt_q <= nx_ctl.cnt;
			out_esc_q <= nx_ctl.esc;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.iter_count = out_cnt_q;
	assign result.escaped    = out_esc_q;

	// Points in flight never outnumber the ring slots.
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		TAG_W'(in_tag_q - out_tag_q) <= TAG_W'(RING_STAGES))
		else $error("more points in flight than ring stages");

	// A live, unfinished slot always has a multiply left to do.
	a_kleft: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s5.vld && !ctl_s5.done) |-> (ctl_s5.k != 2'd0))
		else $error("unfinished slot with no multiply pending");

	// Every emit fills the output register and advances the oldest tag by one.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_vld_q && (out_tag_q == $past(out_tag_q) + 1'b1)))
		else $error("result emitted out of order");

endmodule
